// ===== rtl/core/pwpi_pkg.sv =====
// Shared types, constants and arithmetic helpers of the particle wall penalty integrator.
`default_nettype none

package pwpi_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned DT_W      = 21;
    localparam int unsigned FRAC_W    = 20;
    localparam int unsigned NUM_AXES  = 3;
    localparam int unsigned CFG_IDX_W = 3;

    localparam int unsigned IN_FIELDS  = 4 * NUM_AXES;
    localparam int unsigned OUT_FIELDS = 3 * NUM_AXES;
    localparam int unsigned IN_W       = IN_FIELDS * DATA_W;
    localparam int unsigned OUT_W      = OUT_FIELDS * DATA_W;

    // value times dt, and the rounded Q12.20 step that comes out of it
    localparam int unsigned PROD_W  = DATA_W + DT_W;
    localparam int unsigned STEP_W  = PROD_W - FRAC_W;
    localparam int unsigned PRE_W   = DATA_W + 2;
    localparam int unsigned DEPTH_W = PRE_W + 2;
    localparam int unsigned PEN_W   = 52;
    localparam int unsigned ACC_W   = PEN_W + 2;
    localparam int unsigned SAT_W   = ACC_W;

    localparam logic signed [DEPTH_W-1:0] WALL_REACH   = 8389;
    localparam logic signed [DEPTH_W-1:0] WALL_EPS     = 10;
    localparam logic signed [PEN_W-1:0]   WALL_STIFF   = 30000;
    localparam int unsigned               WALL_DAMP_SH = 7;
    localparam int unsigned               AXIS_Y       = 1;

    localparam logic [CFG_IDX_W-1:0] REG_WALL_X_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WALL_X_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WALL_Y_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WALL_Y_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WALL_Z_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WALL_Z_HIGH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_Y   = 3'd7;

    localparam logic signed [DATA_W-1:0] RST_WALL_X_LOW  = -32'sd52429;
    localparam logic signed [DATA_W-1:0] RST_WALL_X_HIGH = 32'sd52429;
    localparam logic signed [DATA_W-1:0] RST_WALL_Y_LOW  = 32'sd0;
    localparam logic signed [DATA_W-1:0] RST_WALL_Y_HIGH = 32'sd1048576;
    localparam logic signed [DATA_W-1:0] RST_WALL_Z_LOW  = -32'sd52429;
    localparam logic signed [DATA_W-1:0] RST_WALL_Z_HIGH = 32'sd52429;
    localparam logic        [DT_W-1:0]   RST_TIME_STEP   = 21'd1049;
    localparam logic signed [DATA_W-1:0] RST_GRAVITY_Y   = -32'sd10276045;

    typedef logic signed [DATA_W-1:0]  t_word;
    typedef t_word [NUM_AXES-1:0]      t_vec;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef t_prod [NUM_AXES-1:0]      t_prod_vec;
    typedef logic signed [PRE_W-1:0]   t_pre;
    typedef t_pre [NUM_AXES-1:0]       t_pre_vec;

    typedef struct packed {
        t_vec             wall_lo;
        t_vec             wall_hi;
        logic [DT_W-1:0]  time_step;
        t_word            gravity_y;
    } t_cfg;

    // signed value times the unsigned time step, exact
    function automatic t_prod mul_dt(input t_word x, input logic [DT_W-1:0] dt);
        logic signed [DT_W:0] dt_s;
        dt_s = $signed({1'b0, dt});
        return PROD_W'(x) * PROD_W'(dt_s);
    endfunction

    // drop the fraction: round to nearest, ties toward plus infinity
    function automatic logic signed [STEP_W-1:0] round_dt(input t_prod p);
        t_prod s;
        s = p + PROD_W'(1 << (FRAC_W - 1));
        return s[PROD_W-1:FRAC_W];
    endfunction

    function automatic t_word sat_word(input logic signed [SAT_W-1:0] x);
        logic [SAT_W-DATA_W:0] upper;
        upper = x[SAT_W-1:DATA_W-1];
        if ((&upper) || !(|upper)) begin
            return x[DATA_W-1:0];
        end else if (x[SAT_W-1]) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/particle_wall_penalty_integrator_top.sv =====
// Throughput: one particle per cycle while the master side accepts; three multiplier stages
// (v*dt, a*dt, v'*dt) in sequence. Each stage holds its item on a stall and empty stages
// fill, so no bubble is kept. Reset (synchronous, active low) clears all stage valid bits
// and loads the default box, time step and gravity into the configuration registers.
`default_nettype none

module particle_wall_penalty_integrator_top
    import pwpi_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DATA_W-1:0]    i_cfg_data,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // pos_x, pos_y, pos_z, veval_x, veval_y, veval_z,
    // vmean_x, vmean_y, vmean_z, acc_x, acc_y, acc_z; 32 bits each, lowest first
    input  wire logic [IN_W-1:0]      s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // new_pos_x, new_pos_y, new_pos_z, new_veval_x, new_veval_y, new_veval_z,
    // new_vmean_x, new_vmean_y, new_vmean_z; 32 bits each, lowest first
    output logic [OUT_W-1:0]          m_axis_tdata
);

    t_cfg r_cfg;

    t_vec in_pos, in_ve, in_vm, in_acc;

    logic     pr_valid, pr_ready;
    t_pre_vec pr_pre;
    t_vec     pr_pos, pr_ve, pr_vm, pr_acc;

    logic     wl_valid, wl_ready;
    t_vec     wl_total, wl_pos, wl_ve;

    t_vec     out_pos, out_ve, out_vm;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wall_lo[0] <= RST_WALL_X_LOW;
            r_cfg.wall_hi[0] <= RST_WALL_X_HIGH;
            r_cfg.wall_lo[1] <= RST_WALL_Y_LOW;
            r_cfg.wall_hi[1] <= RST_WALL_Y_HIGH;
            r_cfg.wall_lo[2] <= RST_WALL_Z_LOW;
            r_cfg.wall_hi[2] <= RST_WALL_Z_HIGH;
            r_cfg.time_step  <= RST_TIME_STEP;
            r_cfg.gravity_y  <= RST_GRAVITY_Y;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_WALL_X_LOW:  r_cfg.wall_lo[0] <= i_cfg_data;
                REG_WALL_X_HIGH: r_cfg.wall_hi[0] <= i_cfg_data;
                REG_WALL_Y_LOW:  r_cfg.wall_lo[1] <= i_cfg_data;
                REG_WALL_Y_HIGH: r_cfg.wall_hi[1] <= i_cfg_data;
                REG_WALL_Z_LOW:  r_cfg.wall_lo[2] <= i_cfg_data;
                REG_WALL_Z_HIGH: r_cfg.wall_hi[2] <= i_cfg_data;
                REG_TIME_STEP:   r_cfg.time_step  <= i_cfg_data[DT_W-1:0];
                REG_GRAVITY_Y:   r_cfg.gravity_y  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            in_pos[a] = s_axis_tdata[(0 * NUM_AXES + a) * DATA_W +: DATA_W];
            in_ve[a]  = s_axis_tdata[(1 * NUM_AXES + a) * DATA_W +: DATA_W];
            in_vm[a]  = s_axis_tdata[(2 * NUM_AXES + a) * DATA_W +: DATA_W];
            in_acc[a] = s_axis_tdata[(3 * NUM_AXES + a) * DATA_W +: DATA_W];
        end
    end

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            m_axis_tdata[(0 * NUM_AXES + a) * DATA_W +: DATA_W] = out_pos[a];
            m_axis_tdata[(1 * NUM_AXES + a) * DATA_W +: DATA_W] = out_ve[a];
            m_axis_tdata[(2 * NUM_AXES + a) * DATA_W +: DATA_W] = out_vm[a];
        end
    end

    pwpi_predict u_predict (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_pos   (in_pos),
        .i_veval (in_ve),
        .i_vmean (in_vm),
        .i_acc   (in_acc),
        .o_valid (pr_valid),
        .i_ready (pr_ready),
        .o_pre   (pr_pre),
        .o_pos   (pr_pos),
        .o_veval (pr_ve),
        .o_vmean (pr_vm),
        .o_acc   (pr_acc)
    );

    pwpi_wall u_wall (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (pr_valid),
        .o_ready (pr_ready),
        .i_pre   (pr_pre),
        .i_pos   (pr_pos),
        .i_veval (pr_ve),
        .i_vmean (pr_vm),
        .i_acc   (pr_acc),
        .o_valid (wl_valid),
        .i_ready (wl_ready),
        .o_total (wl_total),
        .o_pos   (wl_pos),
        .o_veval (wl_ve)
    );

    pwpi_integ u_integ (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (wl_valid),
        .o_ready     (wl_ready),
        .i_total     (wl_total),
        .i_pos       (wl_pos),
        .i_veval     (wl_ve),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_new_pos   (out_pos),
        .o_new_veval (out_ve),
        .o_new_vmean (out_vm)
    );

endmodule

`default_nettype wire

// ===== rtl/core/pwpi_predict.sv =====
// Two pipeline stages: velocity times dt, then the predicted position.
`default_nettype none

module pwpi_predict
    import pwpi_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_vec  i_pos,
    input  wire t_vec  i_veval,
    input  wire t_vec  i_vmean,
    input  wire t_vec  i_acc,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_pre_vec   o_pre,
    output t_vec       o_pos,
    output t_vec       o_veval,
    output t_vec       o_vmean,
    output t_vec       o_acc
);

    localparam int unsigned NUM_STG = 2;

    logic [NUM_STG-1:0] r_vld;
    logic [NUM_STG-1:0] adv;

    t_prod_vec r1_prod, n_prod;
    t_vec      r1_pos, r1_ve, r1_vm, r1_acc;
    t_pre_vec  r2_pre, n_pre;
    t_vec      r2_pos, r2_ve, r2_vm, r2_acc;

    // a stage moves on when it is empty or the stage after it moves on
    always_comb begin
        adv[NUM_STG-1] = !r_vld[NUM_STG-1] || i_ready;
        for (int k = NUM_STG - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NUM_STG; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            n_prod[a] = mul_dt(i_veval[a], i_cfg.time_step);
            n_pre[a]  = PRE_W'($signed(r1_pos[a])) + PRE_W'(round_dt(r1_prod[a]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r1_prod <= n_prod;
            r1_pos  <= i_pos;
            r1_ve   <= i_veval;
            r1_vm   <= i_vmean;
            r1_acc  <= i_acc;
        end
        if (adv[1]) begin
            r2_pre <= n_pre;
            r2_pos <= r1_pos;
            r2_ve  <= r1_ve;
            r2_vm  <= r1_vm;
            r2_acc <= r1_acc;
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_vld[NUM_STG-1];
    assign o_pre   = r2_pre;
    assign o_pos   = r2_pos;
    assign o_veval = r2_ve;
    assign o_vmean = r2_vm;
    assign o_acc   = r2_acc;

endmodule

`default_nettype wire

// ===== rtl/core/pwpi_wall.sv =====
// Three pipeline stages: wall depths, penalty products, total acceleration with saturation.
`default_nettype none

module pwpi_wall
    import pwpi_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cfg     i_cfg,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_pre_vec i_pre,
    input  wire t_vec     i_pos,
    input  wire t_vec     i_veval,
    input  wire t_vec     i_vmean,
    input  wire t_vec     i_acc,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_vec          o_total,
    output t_vec          o_pos,
    output t_vec          o_veval
);

    localparam int unsigned NUM_STG = 3;

    logic [NUM_STG-1:0] r_vld;
    logic [NUM_STG-1:0] adv;

    logic signed [DEPTH_W-1:0] r3_dlo [NUM_AXES];
    logic signed [DEPTH_W-1:0] r3_dhi [NUM_AXES];
    logic signed [DEPTH_W-1:0] n_dlo  [NUM_AXES];
    logic signed [DEPTH_W-1:0] n_dhi  [NUM_AXES];
    logic [NUM_AXES-1:0]       r3_flo, r3_fhi, n_flo, n_fhi;
    t_vec                      r3_vm, r3_acc, r3_pos, r3_ve;

    logic signed [PEN_W-1:0]   r4_plo [NUM_AXES];
    logic signed [PEN_W-1:0]   r4_phi [NUM_AXES];
    logic signed [PEN_W-1:0]   n_plo  [NUM_AXES];
    logic signed [PEN_W-1:0]   n_phi  [NUM_AXES];
    logic signed [PEN_W-1:0]   damp   [NUM_AXES];
    t_vec                      r4_acc, r4_pos, r4_ve;

    logic signed [ACC_W-1:0]   sum    [NUM_AXES];
    t_word                     grav   [NUM_AXES];
    t_vec                      r5_total, n_total, r5_pos, r5_ve;

    always_comb begin
        adv[NUM_STG-1] = !r_vld[NUM_STG-1] || i_ready;
        for (int k = NUM_STG - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NUM_STG; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            // distance inside the reach of each wall; the wall pushes when above the margin
            n_dlo[a] = WALL_REACH - DEPTH_W'($signed(i_pre[a]))
                     + DEPTH_W'($signed(i_cfg.wall_lo[a]));
            n_dhi[a] = WALL_REACH - DEPTH_W'($signed(i_cfg.wall_hi[a]))
                     + DEPTH_W'($signed(i_pre[a]));
            n_flo[a] = n_dlo[a] > WALL_EPS;
            n_fhi[a] = n_dhi[a] > WALL_EPS;

            damp[a]  = PEN_W'($signed(r3_vm[a])) <<< WALL_DAMP_SH;
            n_plo[a] = r3_flo[a] ? (WALL_STIFF * PEN_W'(r3_dlo[a]) - damp[a]) : '0;
            n_phi[a] = r3_fhi[a] ? (WALL_STIFF * PEN_W'(r3_dhi[a]) + damp[a]) : '0;

            grav[a]    = (a == AXIS_Y) ? i_cfg.gravity_y : '0;
            sum[a]     = ACC_W'($signed(r4_acc[a])) + ACC_W'(r4_plo[a])
                       - ACC_W'(r4_phi[a]) + ACC_W'(grav[a]);
            n_total[a] = sat_word(SAT_W'(sum[a]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r3_dlo <= n_dlo;
            r3_dhi <= n_dhi;
            r3_flo <= n_flo;
            r3_fhi <= n_fhi;
            r3_vm  <= i_vmean;
            r3_acc <= i_acc;
            r3_pos <= i_pos;
            r3_ve  <= i_veval;
        end
        if (adv[1]) begin
            r4_plo <= n_plo;
            r4_phi <= n_phi;
            r4_acc <= r3_acc;
            r4_pos <= r3_pos;
            r4_ve  <= r3_ve;
        end
        if (adv[2]) begin
            r5_total <= n_total;
            r5_pos   <= r4_pos;
            r5_ve    <= r4_ve;
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_vld[NUM_STG-1];
    assign o_total = r5_total;
    assign o_pos   = r5_pos;
    assign o_veval = r5_ve;

endmodule

`default_nettype wire

// ===== rtl/core/pwpi_integ.sv =====
// Four pipeline stages of leapfrog: new velocity, mean velocity and new position.
`default_nettype none

module pwpi_integ
    import pwpi_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_vec  i_total,
    input  wire t_vec  i_pos,
    input  wire t_vec  i_veval,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_vec       o_new_pos,
    output t_vec       o_new_veval,
    output t_vec       o_new_vmean
);

    localparam int unsigned NUM_STG = 4;

    logic [NUM_STG-1:0] r_vld;
    logic [NUM_STG-1:0] adv;

    t_prod_vec r6_prod, n_prod6;
    t_vec      r6_pos, r6_ve;

    logic signed [SAT_W-1:0] nve_sum [NUM_AXES];
    t_vec      r7_nve, n_nve, r7_pos, r7_ve;

    logic signed [DATA_W:0]  vm_sum  [NUM_AXES];
    t_prod_vec r8_prod, n_prod8;
    t_vec      r8_nve, r8_nvm, n_nvm, r8_pos;

    logic signed [SAT_W-1:0] pos_sum [NUM_AXES];
    t_vec      r9_npos, n_npos, r9_nve, r9_nvm;

    always_comb begin
        adv[NUM_STG-1] = !r_vld[NUM_STG-1] || i_ready;
        for (int k = NUM_STG - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NUM_STG; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            n_prod6[a] = mul_dt(i_total[a], i_cfg.time_step);

            nve_sum[a] = SAT_W'($signed(r6_ve[a])) + SAT_W'(round_dt(r6_prod[a]));
            n_nve[a]   = sat_word(nve_sum[a]);

            n_prod8[a] = mul_dt(r7_nve[a], i_cfg.time_step);
            // floor of half the sum: drop the low bit of the widened sum
            vm_sum[a]  = (DATA_W + 1)'($signed(r7_ve[a])) + (DATA_W + 1)'($signed(r7_nve[a]));
            n_nvm[a]   = vm_sum[a][DATA_W:1];

            pos_sum[a] = SAT_W'($signed(r8_pos[a])) + SAT_W'(round_dt(r8_prod[a]));
            n_npos[a]  = sat_word(pos_sum[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r6_prod <= n_prod6;
            r6_pos  <= i_pos;
            r6_ve   <= i_veval;
        end
        if (adv[1]) begin
            r7_nve <= n_nve;
            r7_pos <= r6_pos;
            r7_ve  <= r6_ve;
        end
        if (adv[2]) begin
            r8_prod <= n_prod8;
            r8_nve  <= r7_nve;
            r8_nvm  <= n_nvm;
            r8_pos  <= r7_pos;
        end
        if (adv[3]) begin
            r9_npos <= n_npos;
            r9_nve  <= r8_nve;
            r9_nvm  <= r8_nvm;
        end
    end

    assign o_ready     = adv[0];
    assign o_valid     = r_vld[NUM_STG-1];
    assign o_new_pos   = r9_npos;
    assign o_new_veval = r9_nve;
    assign o_new_vmean = r9_nvm;

endmodule

`default_nettype wire

// ===== tb/tb_particle_wall_penalty_integrator_top.sv =====
// Self-checking testbench for the particle wall penalty integrator top level.
module tb_particle_wall_penalty_integrator_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pwpi_pkg::*;

    // one particle and one update, first field in the lowest bits
    typedef struct packed {
        t_vec acc;
        t_vec vmean;
        t_vec veval;
        t_vec pos;
    } t_particle;

    typedef struct packed {
        t_vec vmean;
        t_vec veval;
        t_vec pos;
    } t_update;

    localparam int     NUM_REGS         = 8;
    localparam int     RESET_CYCLES     = 7;
    localparam int     SINK_HOLD_CYCLES = 400;
    localparam int     TAIL_CYCLES      = 30;
    localparam int     MAX_REPORTS      = 40;
    localparam int     LIMIT_NS         = 2_000_000;
    localparam int     AXIS_Y_IDX       = 1;
    localparam longint PEN_REACH        = 8389;
    localparam longint PEN_EPS          = 10;
    localparam longint PEN_STIFF        = 30000;
    localparam longint PEN_DAMP         = 128;
    localparam longint WORD_MAX_L       = 64'sd2147483647;
    localparam longint WORD_MIN_L       = -64'sd2147483648;
    localparam t_word  WORD_MAX         = 32'sh7FFF_FFFF;
    localparam t_word  WORD_MIN         = 32'sh8000_0000;
    localparam logic [DT_W-1:0] DT_ALL_ONES = 21'h1F_FFFF;
    localparam logic [DT_W-1:0] DT_ONE_SEC  = 21'd1048576;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DATA_W-1:0]    i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;

    t_cfg    box_cfg;
    t_update expected_updates[$];
    int      mismatch_count = 0;
    int      update_count = 0;
    bit      idle_en = 1'b1;
    bit      sink_hold_req = 1'b0;

    particle_wall_penalty_integrator_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic longint clamp_word(input longint x);
        if (x > WORD_MAX_L) return WORD_MAX_L;
        if (x < WORD_MIN_L) return WORD_MIN_L;
        return x;
    endfunction

    // round to nearest, ties toward plus infinity
    function automatic longint scale_by_dt(input longint x);
        longint prod;
        prod = x * longint'(box_cfg.time_step) + (longint'(1) <<< (FRAC_W - 1));
        return prod >>> FRAC_W;
    endfunction

    function automatic t_update integrate_particle(input t_particle p);
        t_update u;
        longint  pos, ve, vm, acc, pre, depth, nve, npos;
        int      a;
        for (a = 0; a < NUM_AXES; a++) begin
            pos = longint'($signed(p.pos[a]));
            ve  = longint'($signed(p.veval[a]));
            vm  = longint'($signed(p.vmean[a]));
            acc = longint'($signed(p.acc[a]));
            pre = pos + scale_by_dt(ve);
            depth = PEN_REACH - (pre - longint'($signed(box_cfg.wall_lo[a])));
            if (depth > PEN_EPS) begin
                acc = acc + PEN_STIFF * depth - PEN_DAMP * vm;
            end
            depth = PEN_REACH - (longint'($signed(box_cfg.wall_hi[a])) - pre);
            if (depth > PEN_EPS) begin
                acc = acc - (PEN_STIFF * depth + PEN_DAMP * vm);
            end
            if (a == AXIS_Y_IDX) begin
                acc = acc + longint'($signed(box_cfg.gravity_y));
            end
            nve  = clamp_word(ve + scale_by_dt(clamp_word(acc)));
            npos = clamp_word(pos + scale_by_dt(nve));
            u.pos[a]   = t_word'(npos);
            u.veval[a] = t_word'(nve);
            u.vmean[a] = t_word'((ve + nve) >>> 1);
        end
        return u;
    endfunction

    // ---------------------------------------------------------------- builders

    function automatic t_vec vec3(input t_word x, input t_word y, input t_word z);
        t_vec v;
        v[0] = x;
        v[1] = y;
        v[2] = z;
        return v;
    endfunction

    function automatic t_vec splat(input t_word w);
        return vec3(w, w, w);
    endfunction

    function automatic t_particle particle_of(input t_vec pos, input t_vec ve,
                                              input t_vec vm, input t_vec acc);
        t_particle p;
        p.pos   = pos;
        p.veval = ve;
        p.vmean = vm;
        p.acc   = acc;
        return p;
    endfunction

    function automatic t_cfg default_box();
        t_cfg c;
        c.wall_lo   = vec3(-32'sd52429, 32'sd0, -32'sd52429);
        c.wall_hi   = vec3(32'sd52429, 32'sd1048576, 32'sd52429);
        c.time_step = 21'd1049;
        c.gravity_y = -32'sd10276045;
        return c;
    endfunction

    function automatic t_word rand_extreme();
        return ($urandom_range(0, 1) != 0) ? WORD_MAX : WORD_MIN;
    endfunction

    function automatic t_word rand_signed(input int mag_bits);
        longint span;
        span = longint'(1) <<< mag_bits;
        return t_word'(longint'($urandom_range(0, int'(2 * span))) - span);
    endfunction

    function automatic t_word rand_value(input int mag_bits);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6) return rand_signed(mag_bits);
        if (r < 8) return t_word'($urandom);
        if (r == 8) return rand_extreme();
        return '0;
    endfunction

    // most positions land in the band where the wall penalty turns on
    function automatic t_word rand_coord(input int a);
        longint lo, hi, off;
        lo  = longint'($signed(box_cfg.wall_lo[a]));
        hi  = longint'($signed(box_cfg.wall_hi[a]));
        off = longint'($urandom_range(0, 32768)) - 16384;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return t_word'(clamp_word(lo + off));
            4, 5, 6:    return t_word'(clamp_word(hi + off));
            7:          return t_word'(clamp_word((lo + hi) / 2 + off * 16));
            8:          return t_word'($urandom);
            default:    return rand_extreme();
        endcase
    endfunction

    function automatic t_particle random_particle();
        t_particle p;
        int        a;
        for (a = 0; a < NUM_AXES; a++) begin
            p.pos[a]   = rand_coord(a);
            p.veval[a] = rand_value(22);
            p.vmean[a] = rand_value(22);
            p.acc[a]   = rand_value(27);
        end
        return p;
    endfunction

    function automatic t_cfg random_box();
        t_cfg   c;
        int     a;
        longint lo;
        for (a = 0; a < NUM_AXES; a++) begin
            lo = longint'(rand_signed(21));
            case ($urandom_range(0, 5))
                0, 1, 2: begin
                    c.wall_lo[a] = t_word'(lo);
                    c.wall_hi[a] = t_word'(lo + longint'($urandom_range(0, 1 << 21)));
                end
                3: begin
                    c.wall_lo[a] = t_word'($urandom);
                    c.wall_hi[a] = t_word'($urandom);
                end
                4: begin
                    c.wall_lo[a] = WORD_MIN;
                    c.wall_hi[a] = WORD_MAX;
                end
                default: begin
                    // inverted box: both walls of the axis can push at once
                    c.wall_lo[a] = t_word'(lo);
                    c.wall_hi[a] = t_word'(lo - longint'($urandom_range(0, 20000)));
                end
            endcase
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: c.time_step = DT_W'($urandom_range(1, 4096));
            6, 7:             c.time_step = DT_W'($urandom_range(0, int'(DT_ONE_SEC)));
            8:                c.time_step = ($urandom_range(0, 1) != 0) ? DT_ALL_ONES : '0;
            default:          c.time_step = DT_W'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: c.gravity_y = rand_signed(24);
            7, 8:                c.gravity_y = t_word'($urandom);
            default:             c.gravity_y = rand_extreme();
        endcase
        return c;
    endfunction

    // mostly back-to-back, sometimes short gaps, rarely long ones; none while idle_en is clear
    function automatic int pick_gap();
        int unsigned r;
        if (!idle_en) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic write_settings(input t_cfg c);
        logic [DATA_W-1:0]    val;
        logic [CFG_IDX_W-1:0] idx;
        int                   i;
        for (i = 0; i < NUM_REGS; i++) begin
            idx = CFG_IDX_W'(i);
            case (idx)
                REG_WALL_X_LOW:  val = c.wall_lo[0];
                REG_WALL_X_HIGH: val = c.wall_hi[0];
                REG_WALL_Y_LOW:  val = c.wall_lo[1];
                REG_WALL_Y_HIGH: val = c.wall_hi[1];
                REG_WALL_Z_LOW:  val = c.wall_lo[2];
                REG_WALL_Z_HIGH: val = c.wall_hi[2];
                REG_TIME_STEP: begin
                    // upper bits carry noise; only the low field counts
                    val = $urandom;
                    val[DT_W-1:0] = c.time_step;
                end
                default:         val = c.gravity_y;
            endcase
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= val;
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        box_cfg = c;
    endtask

    task automatic send_particle(input t_particle p);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= p;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_updates.push_back(integrate_particle(p));
    endtask

    // drop valid, then hold until every pending update has come back
    task automatic end_phase();
        s_axis_tvalid <= 1'b0;
        while (expected_updates.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_random(input int n);
        int i;
        for (i = 0; i < n; i++) send_particle(random_particle());
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_walls_at_reset();
        t_word lo_x;
        t_vec  mid;
        lo_x = -32'sd52429;
        mid  = vec3('0, 32'sd524288, '0);
        send_particle(particle_of(mid, '0, '0, '0));
        send_particle(particle_of(vec3(lo_x + 4000, 32'sd524288, '0),
                                  vec3(-32'sd200000, '0, '0), vec3(-32'sd300000, '0, '0), '0));
        send_particle(particle_of(vec3(32'sd48429, 32'sd524288, '0),
                                  vec3(32'sd200000, '0, '0), vec3(32'sd250000, '0, '0), '0));
        send_particle(particle_of(vec3('0, -32'sd100000, '0), '0,
                                  vec3('0, -32'sd500000, '0), '0));
        send_particle(particle_of(vec3('0, 32'sd1098576, '0), vec3('0, 32'sd800000, '0),
                                  vec3('0, 32'sd400000, '0), '0));
        send_particle(particle_of(vec3('0, 32'sd524288, -32'sd51429), '0,
                                  vec3('0, '0, -32'sd90000), vec3('0, '0, 32'sd1000)));
        send_particle(particle_of(vec3('0, 32'sd524288, 32'sd60000), '0,
                                  vec3('0, '0, 32'sd90000), '0));
        // penetration right at the threshold, then one step past it
        send_particle(particle_of(vec3(lo_x + 8379, 32'sd524288, '0), '0, '0, '0));
        send_particle(particle_of(vec3(lo_x + 8378, 32'sd524288, '0), '0, '0, '0));
        send_particle(particle_of(splat(WORD_MAX), splat(WORD_MAX), splat(WORD_MAX),
                                  splat(WORD_MAX)));
        send_particle(particle_of(splat(WORD_MIN), splat(WORD_MIN), splat(WORD_MIN),
                                  splat(WORD_MIN)));
        send_particle(particle_of('0, '0, '0, '0));
        send_particle(particle_of(mid, vec3(WORD_MAX, WORD_MIN, WORD_MAX), '0,
                                  vec3(WORD_MAX, WORD_MIN, WORD_MIN)));
        send_particle(particle_of(splat(WORD_MAX), splat(WORD_MIN), splat(WORD_MAX),
                                  splat(WORD_MIN)));
        end_phase();
    endtask

    task automatic test_extreme_settings();
        t_cfg c;
        // widest box, longest step the field holds, strongest upward gravity
        c.wall_lo   = splat(WORD_MIN);
        c.wall_hi   = splat(WORD_MAX);
        c.time_step = DT_ALL_ONES;
        c.gravity_y = WORD_MAX;
        write_settings(c);
        send_particle(particle_of(splat(WORD_MAX), splat(WORD_MAX), splat(WORD_MAX),
                                  splat(WORD_MAX)));
        send_particle(particle_of(splat(WORD_MIN), splat(WORD_MIN), splat(WORD_MIN),
                                  splat(WORD_MIN)));
        send_particle(particle_of('0, splat(32'sd1000), '0, splat(-32'sd5000)));
        send_particle(particle_of(vec3(WORD_MAX, '0, WORD_MIN), splat(WORD_MAX), '0,
                                  splat(WORD_MAX)));
        end_phase();

        // zero step and an inverted box: every wall of every axis is active
        c.wall_lo   = splat(WORD_MAX);
        c.wall_hi   = splat(WORD_MIN);
        c.time_step = '0;
        c.gravity_y = WORD_MIN;
        write_settings(c);
        send_particle(particle_of('0, '0, '0, '0));
        send_particle(particle_of(splat(WORD_MAX), splat(WORD_MAX), splat(WORD_MAX),
                                  splat(WORD_MAX)));
        send_particle(particle_of(splat(WORD_MIN), splat(WORD_MIN), splat(WORD_MIN),
                                  splat(WORD_MIN)));
        send_particle(particle_of(splat(WORD_MIN), splat(WORD_MAX), splat(WORD_MIN),
                                  splat(WORD_MAX)));
        end_phase();

        // zero-width box at the origin, one second per step
        c.wall_lo   = '0;
        c.wall_hi   = '0;
        c.time_step = DT_ONE_SEC;
        c.gravity_y = '0;
        write_settings(c);
        send_particle(particle_of('0, splat(32'sd3), splat(-32'sd7), '0));
        send_particle(particle_of(splat(32'sd4000), splat(-32'sd1), splat(32'sd1),
                                  splat(-32'sd1)));
        end_phase();
    endtask

    task automatic test_random_default_box();
        write_settings(default_box());
        send_random(500);
        end_phase();
    endtask

    task automatic test_output_backpressure();
        // stall the sink long enough for the pipeline to fill and push back
        idle_en = 1'b0;
        sink_hold_req = 1'b1;
        send_random(64);
        end_phase();
        idle_en = 1'b1;
        send_random(86);
        end_phase();
    endtask

    task automatic test_random_boxes();
        int k;
        for (k = 0; k < 6; k++) begin
            write_settings(random_box());
            idle_en = (k != 2);
            send_random(220);
            end_phase();
        end
        idle_en = 1'b1;
    endtask

    // ---------------------------------------------------------------- sink and checker

    initial begin : sink_ready_gen
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (sink_hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge i_clk);
                sink_hold_req = 1'b0;
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_REPORTS) begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    task automatic compare_word(input string name, input int a,
                                input t_word got, input t_word want);
        if (got !== want) begin
            report_mismatch($sformatf("update %0d %s[%0d]: got %0d, want %0d",
                                      update_count, name, a, got, want));
        end
    endtask

    task automatic check_update(input t_update got);
        t_update want;
        int      a;
        if (expected_updates.size() == 0) begin
            report_mismatch($sformatf("update %0d arrived with no request pending",
                                      update_count));
        end else begin
            want = expected_updates.pop_front();
            for (a = 0; a < NUM_AXES; a++) begin
                compare_word("new_pos", a, got.pos[a], want.pos[a]);
                compare_word("new_veval", a, got.veval[a], want.veval[a]);
                compare_word("new_vmean", a, got.vmean[a], want.vmean[a]);
            end
        end
        update_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            check_update(m_axis_tdata);
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        box_cfg = default_box();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_walls_at_reset();
        test_extreme_settings();
        test_random_default_box();
        test_output_backpressure();
        test_random_boxes();

        end_phase();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_updates.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #LIMIT_NS;
        $display("TIMEOUT: %0d updates still pending", expected_updates.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== particle_wall_penalty_integrator_top.f =====
rtl/core/pwpi_pkg.sv
rtl/core/pwpi_predict.sv
rtl/core/pwpi_wall.sv
rtl/core/pwpi_integ.sv
rtl/core/particle_wall_penalty_integrator_top.sv
tb/tb_particle_wall_penalty_integrator_top.sv
